// ===== sv/kstg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kstg_pkg: shared types, constants and tables of the keyed sine tone generator
// Note keys and phase steps, the quarter-wave sine magnitude table, the
// register indexes and the job record passed from front to back.
// ----------------------------------------------------------------------------
package kstg_pkg;

    // sizing
    localparam int NOTE_COUNT      = 13;
    localparam int SINE_ENTRIES    = 1024;
    localparam int PHASE_BITS      = 32;
    localparam int SINE_BITS       = $clog2(SINE_ENTRIES);
    localparam int QUARTER_ENTRIES = SINE_ENTRIES / 4;
    localparam int QUARTER_BITS    = SINE_BITS - 2;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    // field widths
    localparam int AMP_BITS    = 15;
    localparam int LEN_BITS    = 16;
    localparam int KEY_BITS    = 8;
    localparam int SAMPLE_BITS = 16;

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AMPLITUDE   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NOTE_LENGTH = 2'd1;
    localparam logic [AMP_BITS-1:0] AMPLITUDE_RESET   = 15'd10000;
    localparam logic [LEN_BITS-1:0] NOTE_LENGTH_RESET = 16'd13230;

    // item op codes
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [KEY_BITS-1:0] KEY_HALT = 8'h2E;

    typedef logic [PHASE_BITS-1:0]   phase_t;
    typedef logic [SINE_BITS-1:0]    sine_idx_t;
    typedef logic [AMP_BITS-1:0]     sine_mag_t;
    typedef logic [KEY_BITS-1:0]     key_t;
    typedef logic [LEN_BITS-1:0]     len_t;
    typedef sine_mag_t quarter_table_t [QUARTER_ENTRIES];

    // one sample job from front to back
    typedef struct packed {
        sine_idx_t idx;
        logic      last;
    } tone_job_t;

    // chromatic keys upward from middle c
    localparam key_t NOTE_KEYS [13] = '{
        8'h61, 8'h77, 8'h73, 8'h65, 8'h64, 8'h66, 8'h74,
        8'h67, 8'h79, 8'h68, 8'h75, 8'h6A, 8'h6B
    };

    // phase steps at 32 bits of phase, 44.1 khz
    localparam logic [31:0] NOTE_STEPS32 [13] = '{
        32'd25480551, 32'd26995703, 32'd28600951, 32'd30301652, 32'd32103482,
        32'd34012455, 32'd36034941, 32'd38177690, 32'd40447853, 32'd42853008,
        32'd45401180, 32'd48100875, 32'd50961102
    };

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // phase step of a note at the configured phase width
    function automatic phase_t note_step(input int i);
        logic [31:0] s;
        s = NOTE_STEPS32[i] >> (32 - PHASE_BITS);
        return s[PHASE_BITS-1:0];
    endfunction

    // sin(x) in q30 over [0, pi/2], nine series terms
    function automatic logic [63:0] quarter_sine_q30(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd272;
        sum  = sum + $signed(term);
        if (sum < 0)
        begin
            sum = '0;
        end
        return $unsigned(sum);
    endfunction

    // q15 magnitude at quarter-wave position m (0 .. QUARTER_ENTRIES)
    function automatic sine_mag_t quarter_mag(input int m);
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] v;
        x = (HALF_PI_Q30 * 64'(4 * m)) / SINE_ENTRIES;
        s = quarter_sine_q30(x);
        v = (s + 64'd16384) >> 15;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[AMP_BITS-1:0];
    endfunction

    function automatic quarter_table_t build_quarter_table();
        quarter_table_t t;
        for (int m = 0; m < QUARTER_ENTRIES; m++)
        begin
            t[m] = quarter_mag(m);
        end
        return t;
    endfunction

    localparam quarter_table_t QUARTER_TABLE = build_quarter_table();
    localparam sine_mag_t      QUARTER_PEAK  = quarter_mag(QUARTER_ENTRIES);

endpackage

// ===== sv/kstg_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kstg_in_if: command channel
// Carries key presses and sample ticks with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface kstg_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] key_code;

    modport source (output valid, output op, output key_code, input ready);
    modport sink   (input valid, input op, input key_code, output ready);
endinterface

// ===== sv/kstg_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kstg_out_if: audio channel
// Carries signed samples and the last-of-note flag with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface kstg_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

// ===== sv/keyed_sine_tone_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_sine_tone_generator_top: keyboard-driven sine tone generator
// Key presses select a note, sample ticks produce scaled sine samples.
// ----------------------------------------------------------------------------
// Usage:
//   cmd   - request channel. op = 0 is a key press in key_code, op = 1 is one
//           sample tick. One request is taken every cycle while the job queue
//           has room; every request, of any kind, waits while it is full.
//   audio - one signed 16-bit sample per sounding tick, last marks the final
//           sample of the note.
//   cfg   - cfg_wr_en writes cfg_data to register cfg_index (0 amplitude,
//           1 note length) at the clock edge; write only while idle.
// Path: an accepted tick passes through the job queue, the sine lookup stage
//   and the multiply into the output register before its sample is valid.
// Throughput: one request per cycle while the job queue has room, set by the
//   phase update in the front end; the two-entry job queue, the lookup stage
//   and the output register absorb a stalled receiver, and cmd.ready drops
//   only once the queue is full.
// Reset: phase, note step, note count and halt clear; amplitude returns to
//   10000 and note length to 13230. A '.' key halts the block until reset.
// ----------------------------------------------------------------------------
module keyed_sine_tone_generator_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    kstg_in_if.sink                              cmd,
    kstg_out_if.source                           audio,
    input  logic                                 cfg_wr_en,
    input  logic [kstg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [kstg_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import kstg_pkg::*;

    sine_mag_t amplitude_reg;
    sine_mag_t amplitude_next;
    len_t      note_length_reg;
    len_t      note_length_next;

    logic      job_push;
    tone_job_t push_job;
    logic      queue_full;
    logic      head_valid;
    tone_job_t head_job;
    logic      pop;

    // register write decode
    always_comb
    begin
        amplitude_next   = amplitude_reg;
        note_length_next = note_length_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_AMPLITUDE:   amplitude_next   = cfg_data[AMP_BITS-1:0];
                CFG_NOTE_LENGTH: note_length_next = cfg_data[LEN_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg   <= AMPLITUDE_RESET;
            note_length_reg <= NOTE_LENGTH_RESET;
        end
        else
        begin
            amplitude_reg   <= amplitude_next;
            note_length_reg <= note_length_next;
        end
    end

    // front end: decode and phase keeping
    kstg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .note_length (note_length_reg),
        .queue_full  (queue_full),
        .job_push    (job_push),
        .job         (push_job)
    );

    // job queue
    kstg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_job   (push_job),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job),
        .full       (queue_full)
    );

    // back end: lookup and scaling
    kstg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .amplitude  (amplitude_reg),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .audio      (audio)
    );

endmodule

// ===== sv/kstg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kstg_front: command front end
// Accepts requests, decodes keys, keeps phase, step, note count and halt,
// and posts one sample job per sounding tick.
// ----------------------------------------------------------------------------
module kstg_front (
    input  logic                 clk,
    input  logic                 rst_n,
    kstg_in_if.sink              cmd,
    input  kstg_pkg::len_t       note_length,
    input  logic                 queue_full,
    output logic                 job_push,
    output kstg_pkg::tone_job_t  job
);
    import kstg_pkg::*;

    phase_t phase_reg;
    phase_t phase_next;
    phase_t step_reg;
    phase_t step_next;
    len_t   left_reg;
    len_t   left_next;
    logic   halted_reg;
    logic   halted_next;
    logic   accept;
    logic   key_hit;
    phase_t key_step;

    assign cmd.ready = !queue_full;
    assign accept    = cmd.valid && cmd.ready;

    // job fields come straight from the current phase and count
    assign job.idx  = phase_reg[PHASE_BITS-1 -: SINE_BITS];
    assign job.last = (left_reg == len_t'(1));

    // note key lookup
    always_comb
    begin
        key_hit  = 1'b0;
        key_step = '0;
        for (int i = 0; i < NOTE_COUNT; i++)
        begin
            if (cmd.key_code == NOTE_KEYS[i])
            begin
                key_hit  = 1'b1;
                key_step = note_step(i);
            end
        end
    end

    // request handling
    always_comb
    begin
        phase_next  = phase_reg;
        step_next   = step_reg;
        left_next   = left_reg;
        halted_next = halted_reg;
        job_push    = 1'b0;
        if (accept && !halted_reg)
        begin
            if (cmd.op == OP_KEY)
            begin
                if (cmd.key_code == KEY_HALT)
                begin
                    halted_next = 1'b1;
                end
                else if (key_hit)
                begin
                    step_next  = key_step;
                    phase_next = '0;
                    left_next  = note_length;
                end
            end
            else if (left_reg != '0)
            begin
                job_push   = 1'b1;
                left_next  = left_reg - len_t'(1);
                phase_next = phase_reg + step_reg;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            step_reg   <= '0;
            left_reg   <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            step_reg   <= step_next;
            left_reg   <= left_next;
            halted_reg <= halted_next;
        end
    end

endmodule

// ===== sv/kstg_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kstg_queue: job queue
// Short first-in first-out queue of sample jobs between front and back.
// ----------------------------------------------------------------------------
module kstg_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  kstg_pkg::tone_job_t  push_job,
    input  logic                 pop,
    output logic                 head_valid,
    output kstg_pkg::tone_job_t  head_job,
    output logic                 full
);
    import kstg_pkg::*;

    tone_job_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic [QUEUE_CNT_BITS-1:0] count_next;
    logic                      do_pop;

    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign full       = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign do_pop     = pop && head_valid;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== sv/kstg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kstg_back: sample back end
// Looks up the sine magnitude by quarter-wave symmetry, scales it by the
// amplitude and holds the finished sample in the output register.
// ----------------------------------------------------------------------------
module kstg_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kstg_pkg::sine_mag_t  amplitude,
    input  logic                 head_valid,
    input  kstg_pkg::tone_job_t  head_job,
    output logic                 pop,
    kstg_out_if.source           audio
);
    import kstg_pkg::*;

    logic [1:0]              quad;
    logic [QUARTER_BITS-1:0] pos;
    logic [QUARTER_BITS-1:0] mirror;
    sine_mag_t               mag_lookup;

    logic                    a_valid_reg;
    sine_mag_t               a_mag_reg;
    logic                    a_neg_reg;
    logic                    a_last_reg;

    logic [2*AMP_BITS-1:0]   product;
    logic [SAMPLE_BITS-1:0]  scaled;
    logic [SAMPLE_BITS-1:0]  sample_next;

    logic                    out_valid_reg;
    logic [SAMPLE_BITS-1:0]  out_sample_reg;
    logic                    out_last_reg;

    logic                    out_free;
    logic                    a_free;

    // stall chain
    assign out_free = !out_valid_reg || audio.ready;
    assign a_free   = !a_valid_reg || out_free;
    assign pop      = head_valid && a_free;

    // quarter-wave lookup, mirrored in the odd quarters
    assign quad   = head_job.idx[SINE_BITS-1 -: 2];
    assign pos    = head_job.idx[QUARTER_BITS-1:0];
    assign mirror = ~pos + 1'b1;

    always_comb
    begin
        if (!quad[0])
        begin
            mag_lookup = QUARTER_TABLE[pos];
        end
        else if (pos == '0)
        begin
            mag_lookup = QUARTER_PEAK;
        end
        else
        begin
            mag_lookup = QUARTER_TABLE[mirror];
        end
    end

    // lookup stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_free)
        begin
            a_valid_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_mag_reg  <= mag_lookup;
            a_neg_reg  <= quad[1];
            a_last_reg <= head_job.last;
        end
    end

    // scale, truncate toward zero, restore sign
    assign product     = (2*AMP_BITS)'(amplitude) * (2*AMP_BITS)'(a_mag_reg);
    assign scaled      = {1'b0, product[2*AMP_BITS-1 -: AMP_BITS]};
    assign sample_next = a_neg_reg ? (~scaled + 1'b1) : scaled;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && a_valid_reg)
        begin
            out_sample_reg <= sample_next;
            out_last_reg   <= a_last_reg;
        end
    end

    assign audio.valid  = out_valid_reg;
    assign audio.sample = $signed(out_sample_reg);
    assign audio.last   = out_last_reg;

endmodule
